// ===== hdl/text_strip_ring_cache_assert.svh =====
// assertion macros for the text strip ring cache
// used by text_strip_ring_cache.sv; no other dependencies
`ifndef TEXT_STRIP_RING_CACHE_ASSERT_SVH
`define TEXT_STRIP_RING_CACHE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define TSRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsrc same-cycle check failed");

// next-cycle implication, checked while out of reset
`define TSRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsrc next-cycle check failed");

`endif

// ===== hdl/tsrc_pkg.sv =====
// shared types and constants for the text strip ring cache
// no dependencies; imported by tsrc_store and text_strip_ring_cache
`default_nettype none

package tsrc_pkg;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [7:0] MAX_TEXT_LEN = 8'd254;
	localparam int unsigned SLOT_ROWS_LOG2 = 4;
	localparam logic [9:0] CACHE_HEIGHT_RST = 10'd512;

	// one table entry: key, strip geometry and ruby flag
	typedef struct packed {
		logic [63:0] tag;
		logic [7:0]  text_length;
		logic [9:0]  font_size;
		logic [7:0]  glyph_gap;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [23:0] shadow;
		logic [9:0]  width;
		logic [9:0]  height;
		logic [10:0] row;
		logic        ruby;
	} entry_t;

	typedef struct packed {
		logic       found;
		logic [4:0] entry_index;
		logic [9:0] strip_row;
		logic [9:0] entry_width;
		logic [9:0] entry_height;
		logic       ruby_present;
	} res_t;

	function automatic res_t make_hit(input logic [4:0] idx, input entry_t e);
		res_t r;
		r.found        = 1'b1;
		r.entry_index  = idx;
		r.strip_row    = e.row[9:0];
		r.entry_width  = e.width;
		r.entry_height = e.height;
		r.ruby_present = e.ruby;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tsrc_store.sv =====
// entry table of the text strip ring cache: one write port, one registered read port
// depends on tsrc_pkg for the entry type
`default_nettype none

module tsrc_store #(
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tsrc_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output tsrc_pkg::entry_t rdata
);
	import tsrc_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/text_strip_ring_cache.sv =====
// text strip ring cache: fifo ring of atlas strip entries with lookup, add and clear
// depends on tsrc_pkg, tsrc_store and text_strip_ring_cache_assert.svh
//
// s_* carries one request word: s_tuser is the op (lookup, add, clear), s_tdata the key,
// strip size and ruby flag. m_* returns exactly one result word per request: m_tuser is
// the found flag, m_tdata the slot, start row, size and ruby flag (all zero on a miss,
// a failed add, a clear, an unknown op or an over-long text).
// cfg_* writes register 0 (cache height) or 1 (ruby enable); always ready, write only
// while no request is in flight.
// one request at a time; s_tready is high only when the sequencer is idle. m_tvalid rises
// and s_tready returns together, as the emit state passes the result to the output register:
//   clear, unknown op, long text: straight to emit. lookup: scans the stored entries from the
//   oldest, stopping at a hit. add that fits: reduce, place, emit. the first eviction fetches
//   the evicted entry and then its successor through the single table read port, later ones
//   only the next one. after a height shrink, slot wrap-around subtracts once per cycle.
// reset: arst_n clears the table bookkeeping (empty, write row 0, free rows 512), sets
//   cache height 512 and ruby off; table contents are not cleared.
// stall: a result waits in the output register while m_tready is low; the next request
//   is still taken and completes up to its result, which then waits for the register.
`default_nettype none
`include "text_strip_ring_cache_assert.svh"

module text_strip_ring_cache #(
	parameter int unsigned ENTRIES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [9:0]   cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// text_tag, text_length, font_size, color_red, color_green, color_blue,
	// glyph_gap, shadow_color, strip_width, strip_height, has_ruby, zero pad
	input  logic [159:0] s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// entry_index, strip_row, entry_width, entry_height, ruby_present, zero pad
	output logic [39:0]  m_tdata,
	// found
	output logic [0:0]   m_tuser
);
	import tsrc_pkg::*;

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned RW = CW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_LK,
		ST_EV_RD,
		ST_EV_G,
		ST_EV_K,
		ST_EV_CALC,
		ST_PLACE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		GOAL_LOOKUP,
		GOAL_EVICT,
		GOAL_PLACE
	} goal_t;

	state_t             state_q;
	goal_t              goal_q;
	entry_t             req_q;
	res_t               res_q;
	res_t               out_q;
	logic               m_tvalid_q;
	logic [9:0]         ch_q;
	logic               ruby_en_q;
	logic [IW-1:0]      oldest_q;
	logic [CW-1:0]      count_q;
	logic [10:0]        wrow_q;
	logic signed [11:0] free_q;
	logic [RW-1:0]      red_q;
	logic [IW-1:0]      s_q;
	logic [IW-1:0]      slot_q;
	logic [CW-1:0]      iss_q;
	logic               vld_s1;
	logic [IW-1:0]      slot_s1;
	entry_t             g_q;

	entry_t             in_req;
	entry_t             rdata;
	entry_t             wdata;
	logic [IW-1:0]      raddr;
	logic               we;
	logic [9:0]         ch_div;
	logic [CW-1:0]      cap_w;
	logic [CW-1:0]      s_inc;
	logic [IW-1:0]      k_slot;
	logic               in_fits;
	logic               hit;
	logic [10:0]        wrow_calc;
	logic signed [11:0] f_calc;
	logic               fit_calc;

	// request unpack
	always_comb begin
		in_req.tag         = s_tdata[63:0];
		in_req.text_length = s_tdata[71:64];
		in_req.font_size   = s_tdata[81:72];
		in_req.red         = s_tdata[89:82];
		in_req.green       = s_tdata[97:90];
		in_req.blue        = s_tdata[105:98];
		in_req.glyph_gap   = s_tdata[113:106];
		in_req.shadow      = s_tdata[137:114];
		in_req.width       = s_tdata[147:138];
		in_req.height      = s_tdata[157:148];
		in_req.ruby        = s_tdata[158];
		in_req.row         = '0;
	end

	// slot capacity, clamped to 1..ENTRIES
	always_comb begin
		ch_div = 10'(ch_q >> SLOT_ROWS_LOG2);
		if (ch_div == '0) begin
			cap_w = CW'(1);
		end else if (ch_div > 10'(ENTRIES)) begin
			cap_w = CW'(ENTRIES);
		end else begin
			cap_w = CW'(ch_div);
		end
	end

	assign s_inc   = CW'(s_q) + CW'(1);
	assign k_slot  = (s_inc == cap_w) ? '0 : s_inc[IW-1:0];
	assign in_fits = ($signed({2'b00, in_req.font_size}) <= free_q);

	assign hit = vld_s1 &&
		(rdata.tag == req_q.tag) && (rdata.text_length == req_q.text_length) &&
		(rdata.font_size == req_q.font_size) && (rdata.glyph_gap == req_q.glyph_gap) &&
		(rdata.red == req_q.red) && (rdata.green == req_q.green) &&
		(rdata.blue == req_q.blue) && (rdata.shadow == req_q.shadow);

	// eviction step: g_q is the oldest entry, rdata its successor
	always_comb begin
		wrow_calc = wrow_q;
		f_calc    = free_q;
		if (g_q.row >= wrow_q) begin
			f_calc = free_q + $signed({2'b00, g_q.height});
			if (count_q > CW'(1) && rdata.row < wrow_q) begin
				f_calc = $signed({2'b00, ch_q} - {1'b0, wrow_q});
			end
		end else begin
			wrow_calc = '0;
			f_calc    = $signed({1'b0, g_q.row} + {2'b00, g_q.height});
		end
		fit_calc = ($signed({2'b00, req_q.font_size}) <= f_calc);
	end

	always_comb begin
		wdata      = req_q;
		wdata.row  = wrow_q;
		wdata.ruby = req_q.ruby & ruby_en_q;
	end

	assign we    = (state_q == ST_PLACE);
	assign raddr = (state_q == ST_EV_G || state_q == ST_EV_K) ? k_slot : s_q;

	tsrc_store #(
		.DEPTH (ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (slot_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			goal_q     <= GOAL_LOOKUP;
			m_tvalid_q <= 1'b0;
			ch_q       <= CACHE_HEIGHT_RST;
			ruby_en_q  <= 1'b0;
			oldest_q   <= '0;
			count_q    <= '0;
			wrow_q     <= '0;
			free_q     <= $signed({2'b00, CACHE_HEIGHT_RST});
			vld_s1     <= 1'b0;
			iss_q      <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index) begin
					ruby_en_q <= cfg_data[0];
				end else begin
					ch_q <= cfg_data;
				end
			end
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q <= in_req;
						res_q <= '0;
						case (s_tuser)
							OP_CLEAR: begin
								oldest_q <= '0;
								count_q  <= '0;
								wrow_q   <= '0;
								free_q   <= $signed({2'b00, ch_q});
								state_q  <= ST_EMIT;
							end
							OP_LOOKUP: begin
								if (in_req.text_length <= MAX_TEXT_LEN && count_q != '0) begin
									red_q   <= RW'(oldest_q);
									goal_q  <= GOAL_LOOKUP;
									state_q <= ST_RED;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							OP_ADD: begin
								if (in_req.text_length <= MAX_TEXT_LEN) begin
									if (in_fits && count_q < cap_w) begin
										red_q   <= RW'(oldest_q) + RW'(count_q);
										goal_q  <= GOAL_PLACE;
										state_q <= ST_RED;
									end else if (count_q != '0) begin
										red_q   <= RW'(oldest_q);
										goal_q  <= GOAL_EVICT;
										state_q <= ST_RED;
									end else begin
										state_q <= ST_EMIT;
									end
								end else begin
									state_q <= ST_EMIT;
								end
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_RED: begin
					if (red_q >= RW'(cap_w)) begin
						red_q <= red_q - RW'(cap_w);
					end else begin
						case (goal_q)
							GOAL_LOOKUP: begin
								s_q     <= red_q[IW-1:0];
								iss_q   <= '0;
								vld_s1  <= 1'b0;
								state_q <= ST_LK;
							end
							GOAL_EVICT: begin
								s_q     <= red_q[IW-1:0];
								state_q <= ST_EV_RD;
							end
							default: begin
								slot_q  <= red_q[IW-1:0];
								state_q <= ST_PLACE;
							end
						endcase
					end
				end
				ST_LK: begin
					if (hit) begin
						res_q   <= make_hit(5'(slot_s1), rdata);
						vld_s1  <= 1'b0;
						state_q <= ST_EMIT;
					end else if (iss_q == count_q) begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_EMIT;
						end
					end else begin
						s_q     <= k_slot;
						slot_s1 <= s_q;
						iss_q   <= iss_q + CW'(1);
						vld_s1  <= 1'b1;
					end
				end
				ST_EV_RD: begin
					state_q <= ST_EV_G;
				end
				ST_EV_G: begin
					g_q     <= rdata;
					state_q <= ST_EV_CALC;
				end
				ST_EV_K: begin
					state_q <= ST_EV_CALC;
				end
				ST_EV_CALC: begin
					oldest_q <= k_slot;
					count_q  <= count_q - CW'(1);
					wrow_q   <= wrow_calc;
					free_q   <= f_calc;
					if (fit_calc) begin
						red_q   <= RW'(k_slot) + RW'(count_q - CW'(1));
						goal_q  <= GOAL_PLACE;
						state_q <= ST_RED;
					end else if (count_q == CW'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						s_q     <= k_slot;
						g_q     <= rdata;
						state_q <= ST_EV_K;
					end
				end
				ST_PLACE: begin
					wrow_q  <= wrow_q + {1'b0, req_q.height};
					free_q  <= free_q - $signed({2'b00, req_q.height});
					count_q <= count_q + CW'(1);
					res_q   <= make_hit(5'(slot_q), wdata);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						out_q      <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_q.found;
	assign m_tdata   = {4'b0000, out_q.ruby_present, out_q.entry_height, out_q.entry_width,
		out_q.strip_row, out_q.entry_index};

	`TSRC_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(ENTRIES))
	`TSRC_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_LK, iss_q <= count_q)
	`TSRC_ASSERT_IMP(a_place_slot, clk, arst_n, state_q == ST_PLACE, CW'(slot_q) < cap_w)
	`TSRC_ASSERT_NXT(a_place_count, clk, arst_n, state_q == ST_PLACE, count_q == $past(count_q) + CW'(1))
	`TSRC_ASSERT_IMP(a_evict_nonempty, clk, arst_n, state_q == ST_EV_CALC, count_q != '0)

endmodule

`default_nettype wire

// ===== tb/text_strip_ring_cache_tb.sv =====
// self-checking bench for text_strip_ring_cache: directed and random lookup, add and clear
// traffic on the request stream, register writes while idle, results checked in order
// depends on tsrc_pkg and the text_strip_ring_cache rtl
module tb;
	import tsrc_pkg::*;

	localparam int unsigned ENTRY_SLOTS = 32;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic REG_CACHE_HEIGHT = 1'b0;
	localparam logic REG_RUBY_ENABLE = 1'b1;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] tag;
		logic [7:0]  len;
		logic [9:0]  font;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  gap;
		logic [23:0] shadow;
		logic [9:0]  width;
		logic [9:0]  height;
		logic        ruby;
	} strip_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [9:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [159:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0] m_tuser;

	int unsigned source_idle_pct = 11;
	int unsigned sink_stall_pct = 52;
	int unsigned mismatch_count = 0;

	res_t pending_answers[$];
	res_t want_answer;
	strip_req_t recent_keys[$];

	// mirror of the cache bookkeeping
	entry_t atlas [ENTRY_SLOTS];
	int unsigned ring_head;
	int unsigned ring_count;
	logic [10:0] ring_row;
	logic [11:0] ring_free;
	logic [9:0] atlas_height;
	logic ruby_on;

	text_strip_ring_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("text_strip_ring_cache regression: fail");
		$finish;
	end

	function automatic int unsigned ring_capacity();
		int unsigned c;
		c = atlas_height >> SLOT_ROWS_LOG2;
		if (c < 1) c = 1;
		if (c > ENTRY_SLOTS) c = ENTRY_SLOTS;
		return c;
	endfunction

	function automatic bit font_fits(input logic [9:0] font);
		return $signed({2'b00, font}) <= $signed(ring_free);
	endfunction

	function automatic void clear_ring();
		ring_head = 0;
		ring_count = 0;
		ring_row = '0;
		ring_free = 12'(atlas_height);
	endfunction

	function automatic res_t hit_answer(input int unsigned s);
		res_t a;
		a.found = 1'b1;
		a.entry_index = 5'(s);
		a.strip_row = atlas[s].row[9:0];
		a.entry_width = atlas[s].width;
		a.entry_height = atlas[s].height;
		a.ruby_present = atlas[s].ruby;
		return a;
	endfunction

	function automatic bit key_match(input entry_t e, input strip_req_t r);
		return e.tag == r.tag && e.text_length == r.len && e.font_size == r.font &&
			e.glyph_gap == r.gap && e.red == r.red && e.green == r.green &&
			e.blue == r.blue && e.shadow == r.shadow;
	endfunction

	function automatic res_t store_entry(input strip_req_t r);
		int unsigned s;
		s = (ring_head + ring_count) % ring_capacity();
		atlas[s].tag = r.tag;
		atlas[s].text_length = r.len;
		atlas[s].font_size = r.font;
		atlas[s].glyph_gap = r.gap;
		atlas[s].red = r.red;
		atlas[s].green = r.green;
		atlas[s].blue = r.blue;
		atlas[s].shadow = r.shadow;
		atlas[s].width = r.width;
		atlas[s].height = r.height;
		atlas[s].row = ring_row;
		atlas[s].ruby = ruby_on & r.ruby;
		ring_row = ring_row + 11'(r.height);
		ring_free = ring_free - 12'(r.height);
		ring_count++;
		return hit_answer(s);
	endfunction

	function automatic res_t resolve_request(input strip_req_t r);
		res_t miss;
		int unsigned cap;
		int unsigned s;
		int unsigned i;
		int unsigned loops;
		logic [10:0] start;
		logic [9:0] h;
		miss = '0;
		cap = ring_capacity();
		if (r.op == OP_CLEAR) begin
			clear_ring();
			return miss;
		end
		if (r.op == OP_UNKNOWN || r.len > MAX_TEXT_LEN) return miss;
		if (r.op == OP_LOOKUP) begin
			for (i = 0; i < ring_count; i++) begin
				s = (ring_head + i) % cap;
				if (key_match(atlas[s], r)) return hit_answer(s);
			end
			return miss;
		end
		if (font_fits(r.font) && ring_count < cap) return store_entry(r);
		// evict oldest until the new strip fits
		loops = ring_count;
		for (i = 0; i < loops; i++) begin
			s = ring_head % cap;
			start = atlas[s].row;
			h = atlas[s].height;
			if (start >= ring_row) begin
				ring_free = ring_free + 12'(h);
				if (ring_count >= 2 && atlas[(s + 1) % cap].row < ring_row)
					ring_free = 12'(atlas_height) - 12'(ring_row);
			end else begin
				ring_row = '0;
				ring_free = 12'(start) + 12'(h);
			end
			ring_head = (s + 1) % cap;
			ring_count--;
			if (font_fits(r.font)) return store_entry(r);
		end
		return miss;
	endfunction

	function automatic strip_req_t random_request(input logic [1:0] op);
		strip_req_t r;
		r.op = op;
		r.tag = {$urandom, $urandom};
		r.len = 8'($urandom_range(0, MAX_TEXT_LEN));
		r.font = 10'($urandom);
		r.red = 8'($urandom);
		r.green = 8'($urandom);
		r.blue = 8'($urandom);
		r.gap = 8'($urandom);
		r.shadow = 24'($urandom);
		r.width = 10'($urandom);
		r.height = 10'($urandom_range(0, 512));
		r.ruby = 1'($urandom);
		return r;
	endfunction

	function automatic strip_req_t flip_key_bit(input strip_req_t r, input int unsigned field);
		case (field)
		0: r.tag = r.tag ^ (64'd1 << $urandom_range(0, 63));
		1: r.len = r.len ^ (8'd1 << $urandom_range(0, 7));
		2: r.font = r.font ^ (10'd1 << $urandom_range(0, 9));
		3: r.red = r.red ^ (8'd1 << $urandom_range(0, 7));
		4: r.green = r.green ^ (8'd1 << $urandom_range(0, 7));
		5: r.blue = r.blue ^ (8'd1 << $urandom_range(0, 7));
		6: r.gap = r.gap ^ (8'd1 << $urandom_range(0, 7));
		default: r.shadow = r.shadow ^ (24'd1 << $urandom_range(0, 23));
		endcase
		return r;
	endfunction

	function automatic void keep_key(input strip_req_t r);
		recent_keys.push_back(r);
		if (recent_keys.size() > 48) void'(recent_keys.pop_front());
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < 100)
			$display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_request(input strip_req_t r);
		@(negedge clk);
		while ($urandom_range(0, 99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {1'b0, r.ruby, r.height, r.width, r.shadow, r.gap, r.blue, r.green,
			r.red, r.font, r.len, r.tag};
		do @(posedge clk); while (!s_tready);
		pending_answers.push_back(resolve_request(r));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [9:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_CACHE_HEIGHT) atlas_height = value;
		else ruby_on = value[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected word", 64'({m_tuser, m_tdata}), '0);
			end else begin
				want_answer = pending_answers.pop_front();
				if (m_tuser[0] !== want_answer.found)
					report_mismatch("found", 64'(m_tuser[0]), 64'(want_answer.found));
				if (m_tdata[4:0] !== want_answer.entry_index)
					report_mismatch("entry_index", 64'(m_tdata[4:0]),
						64'(want_answer.entry_index));
				if (m_tdata[14:5] !== want_answer.strip_row)
					report_mismatch("strip_row", 64'(m_tdata[14:5]), 64'(want_answer.strip_row));
				if (m_tdata[24:15] !== want_answer.entry_width)
					report_mismatch("entry_width", 64'(m_tdata[24:15]),
						64'(want_answer.entry_width));
				if (m_tdata[34:25] !== want_answer.entry_height)
					report_mismatch("entry_height", 64'(m_tdata[34:25]),
						64'(want_answer.entry_height));
				if (m_tdata[35] !== want_answer.ruby_present)
					report_mismatch("ruby_present", 64'(m_tdata[35]),
						64'(want_answer.ruby_present));
			end
		end
	end

	// every slot gets written once so later capacity changes never reach stale entries
	task automatic test_fill_table();
		strip_req_t r;
		int unsigned i;
		for (i = 0; i < ENTRY_SLOTS; i++) begin
			r = random_request(OP_ADD);
			r.font = 10'($urandom_range(0, 512 - 16 * i));
			r.height = 10'd16;
			if (i == 0) begin
				r.tag = '0;
				r.len = '0;
				r.red = '0;
				r.green = '0;
				r.blue = '0;
				r.gap = '0;
				r.shadow = '0;
				r.width = '0;
			end
			if (i == ENTRY_SLOTS - 1) begin
				r.tag = '1;
				r.len = MAX_TEXT_LEN;
				r.red = '1;
				r.green = '1;
				r.blue = '1;
				r.gap = '1;
				r.shadow = '1;
				r.width = '1;
			end
			send_request(r);
			keep_key(r);
		end
		r = recent_keys[0];
		r.op = OP_LOOKUP;
		send_request(r);
		r = recent_keys[ENTRY_SLOTS - 1];
		r.op = OP_LOOKUP;
		send_request(r);
	endtask

	task automatic test_key_match();
		strip_req_t r;
		int unsigned f;
		for (f = 0; f < 8; f++) begin
			r = flip_key_bit(recent_keys[ENTRY_SLOTS - 1], f);
			r.op = OP_LOOKUP;
			send_request(r);
		end
	endtask

	task automatic test_rejects();
		strip_req_t r;
		r = recent_keys[0];
		r.op = OP_LOOKUP;
		r.len = 8'd255;
		send_request(r);
		r.op = OP_ADD;
		send_request(r);
		send_request(random_request(OP_UNKNOWN));
		// font too big for the whole atlas: evicts everything, then fails
		r = random_request(OP_ADD);
		r.font = '1;
		send_request(r);
		send_request(r);
		r = recent_keys[5];
		r.op = OP_LOOKUP;
		send_request(r);
	endtask

	task automatic test_ruby_strips();
		strip_req_t a;
		strip_req_t b;
		write_register(REG_RUBY_ENABLE, 10'd1);
		a = random_request(OP_ADD);
		a.font = 10'd0;
		a.height = 10'd40;
		a.ruby = 1'b1;
		b = random_request(OP_ADD);
		b.font = 10'd20;
		b.height = 10'd24;
		b.ruby = 1'b0;
		send_request(a);
		send_request(b);
		a.op = OP_LOOKUP;
		send_request(a);
		keep_key(a);
		keep_key(b);
		write_register(REG_RUBY_ENABLE, 10'd0);
		a = random_request(OP_ADD);
		a.font = 10'd8;
		a.height = 10'd16;
		a.ruby = 1'b1;
		send_request(a);
		a.op = OP_LOOKUP;
		send_request(a);
		keep_key(a);
	endtask

	task automatic test_capacity_change();
		strip_req_t r;
		int unsigned i;
		for (i = 0; i < 3; i++) begin
			r = random_request(OP_ADD);
			r.font = 10'($urandom_range(0, 30));
			r.height = 10'($urandom_range(8, 48));
			send_request(r);
			keep_key(r);
		end
		write_register(REG_CACHE_HEIGHT, 10'd16);
		r = recent_keys[recent_keys.size() - 1];
		r.op = OP_LOOKUP;
		send_request(r);
		r = random_request(OP_ADD);
		r.font = 10'd4;
		r.height = 10'd12;
		send_request(r);
		r.op = OP_LOOKUP;
		send_request(r);
		write_register(REG_CACHE_HEIGHT, 10'd300);
		r.op = OP_ADD;
		r.font = 10'd200;
		send_request(r);
		r.op = OP_LOOKUP;
		send_request(r);
		keep_key(r);
		write_register(REG_CACHE_HEIGHT, 10'd512);
		r = recent_keys[recent_keys.size() - 2];
		r.op = OP_LOOKUP;
		send_request(r);
	endtask

	task automatic test_clear();
		strip_req_t r;
		send_request(random_request(OP_CLEAR));
		r = recent_keys[recent_keys.size() - 1];
		r.op = OP_LOOKUP;
		send_request(r);
		r.op = OP_ADD;
		r.font = 10'd512;
		r.height = 10'd512;
		send_request(r);
		r.op = OP_LOOKUP;
		send_request(r);
	endtask

	task automatic retune_cache();
		logic [9:0] h;
		case ($urandom_range(0, 5))
		0: h = 10'd16;
		1: h = 10'd512;
		2: h = 10'($urandom_range(16, 512));
		3: h = 10'(16 * $urandom_range(1, 8));
		4: h = 10'($urandom_range(16, 100));
		default: h = 10'($urandom_range(256, 512));
		endcase
		write_register(REG_CACHE_HEIGHT, h);
		write_register(REG_RUBY_ENABLE, 10'($urandom_range(0, 1)));
	endtask

	task automatic run_traffic(input int unsigned count, input int unsigned src_pct,
			input int unsigned sink_pct);
		strip_req_t r;
		int unsigned n;
		int unsigned pick;
		source_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (n = 0; n < count; n++) begin
			if (n % 120 == 119) retune_cache();
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				if (recent_keys.size() != 0 && $urandom_range(0, 9) < 8) begin
					r = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
					r.op = OP_LOOKUP;
					r.width = 10'($urandom);
					r.height = 10'($urandom_range(0, 512));
					r.ruby = 1'($urandom);
					if ($urandom_range(0, 9) == 0) r = flip_key_bit(r, $urandom_range(0, 7));
				end else begin
					r = random_request(OP_LOOKUP);
				end
			end else if (pick < 88) begin
				r = random_request(OP_ADD);
				if (recent_keys.size() != 0 && $urandom_range(0, 4) == 0) begin
					r.tag = recent_keys[$urandom_range(0, recent_keys.size() - 1)].tag;
				end
				case ($urandom_range(0, 19))
				0, 1: r.font = 10'($urandom);
				2, 3, 4, 5, 6: r.font = 10'($urandom_range(0, atlas_height));
				default: r.font = 10'($urandom_range(0, 24));
				endcase
				case ($urandom_range(0, 19))
				0, 1: r.height = 10'($urandom_range(0, 512));
				2, 3: r.height = 10'd0;
				4, 5, 6, 7, 8: r.height = 10'($urandom_range(0, atlas_height));
				default: r.height = 10'($urandom_range(1, 32));
				endcase
				keep_key(r);
			end else if (pick < 93) begin
				r = random_request(OP_CLEAR);
			end else if (pick < 96) begin
				r = random_request(OP_UNKNOWN);
			end else begin
				r = random_request($urandom_range(0, 1) ? OP_ADD : OP_LOOKUP);
				r.len = 8'd255;
			end
			send_request(r);
		end
	endtask

	initial begin
		for (int unsigned i = 0; i < ENTRY_SLOTS; i++) atlas[i] = '0;
		atlas_height = CACHE_HEIGHT_RST;
		ruby_on = 1'b0;
		clear_ring();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_fill_table();
		test_key_match();
		test_rejects();
		test_ruby_strips();
		test_capacity_change();
		test_clear();
		run_traffic(580, 11, 52);
		run_traffic(580, 52, 11);
		run_traffic(590, 0, 0);
		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("text_strip_ring_cache regression: pass");
		end else begin
			$display("text_strip_ring_cache regression: fail");
		end
		$finish;
	end

endmodule
